### hdl/fr_pkg.sv
// Shared types and constants for the fraction reducer.
// Used by every module under hdl; depends on nothing.
package fr_pkg;

  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned MAG_W       = WORD_BITS - 1;
  localparam int unsigned SHIFT_W     = $clog2(MAG_W);
  localparam int unsigned BIT_CNT_W   = $clog2(MAG_W);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } fr_status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_GCD,
    FSM_DIV,
    FSM_DONE
  } fr_state_e;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] numerator;
    logic signed [WORD_BITS-1:0] denominator;
  } fr_in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] reduced_numerator;
    logic        [WORD_BITS-2:0] reduced_denominator;
    logic                        whole_number;
    fr_status_e                  status;
  } fr_out_t;

  // Classified item as it waits between front and back
  typedef struct packed {
    logic [MAG_W-1:0] mag_num;
    logic [MAG_W-1:0] mag_den;
    logic             neg;
    fr_status_e       status;
  } fr_job_t;

  typedef struct packed {
    logic    valid;
    fr_job_t job;
  } fr_job_wr_t;

endpackage

### hdl/fr_front.sv
// Front end: accepts items, flags zero denominator and overflow, takes magnitudes.
// Depends on fr_pkg.
module fr_front import fr_pkg::*; (
  input  logic       push,
  input  fr_in_t     in_i,
  input  logic       queue_full_i,
  output logic       full,
  output fr_job_wr_t wr_o
);

  localparam logic [WORD_BITS-1:0] MostNeg = {1'b1, {(WORD_BITS-1){1'b0}}};

  logic [WORD_BITS-1:0] num_abs;
  logic [WORD_BITS-1:0] den_abs;
  fr_status_e           status;

  always_comb begin
    num_abs = in_i.numerator[WORD_BITS-1] ? (~in_i.numerator + 1'b1) : in_i.numerator;
    den_abs = in_i.denominator[WORD_BITS-1] ? (~in_i.denominator + 1'b1) : in_i.denominator;
    priority if (in_i.denominator == '0) begin
      status = ST_ZERO_DEN;
    end else if (in_i.numerator == MostNeg || in_i.denominator == MostNeg) begin
      status = ST_OVERFLOW;
    end else begin
      status = ST_OK;
    end
  end

  assign full              = queue_full_i;
  assign wr_o.valid        = push && !queue_full_i;
  assign wr_o.job.mag_num  = num_abs[MAG_W-1:0];
  assign wr_o.job.mag_den  = den_abs[MAG_W-1:0];
  assign wr_o.job.neg      = in_i.numerator[WORD_BITS-1] ^ in_i.denominator[WORD_BITS-1];
  assign wr_o.job.status   = status;

endmodule

### hdl/fr_queue.sv
// Short queue of classified items between front and back.
// Depends on fr_pkg.
module fr_queue import fr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  fr_job_wr_t wr_i,
  input  logic       rd_en_i,
  output logic       full_o,
  output logic       avail_o,
  output fr_job_t    head_o
);

  fr_job_t           slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_d = wr_i.valid ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = rd_en_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + QCNT_W'(wr_i.valid) - QCNT_W'(rd_en_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.valid) begin
      slot_q[wr_ptr_q] <= wr_i.job;
    end
  end

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign avail_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en_i |-> count_q != '0)
    else $error("queue read while empty");
`endif

endmodule

### hdl/fr_back.sv
// Back end: binary GCD, two restoring dividers, sign fix-up and result register.
// Depends on fr_pkg.
module fr_back import fr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    avail_i,
  input  fr_job_t job_i,
  output logic    rd_en_o,
  input  logic    pop,
  output logic    empty,
  output fr_out_t out_o
);

  fr_state_e state_q, state_d;

  logic [MAG_W-1:0]     x_q, x_d, y_q, y_d;
  logic [SHIFT_W-1:0]   k_q, k_d;
  logic [MAG_W-1:0]     g_q, g_d;
  logic [MAG_W-1:0]     qa_q, qa_d, qb_q, qb_d;   // dividends, become quotients
  logic [MAG_W-1:0]     ra_q, ra_d, rb_q, rb_d;   // remainders
  logic [BIT_CNT_W-1:0] cnt_q, cnt_d;
  logic                 neg_q, neg_d;
  fr_status_e           status_q, status_d;
  logic                 res_valid_q, res_valid_d;
  fr_out_t              res_q, res_d;

  logic             gcd_done;
  logic             res_free;
  logic [MAG_W:0]   ra_sh, rb_sh, g_ext;
  logic             ge_a, ge_b;
  logic [WORD_BITS-1:0] num_mag;

  assign gcd_done = (x_q == '0) || (y_q == '0);
  assign res_free = !res_valid_q || pop;
  assign rd_en_o  = (state_q == FSM_IDLE) && avail_i;

  assign g_ext = {1'b0, g_q};
  assign ra_sh = {ra_q, qa_q[MAG_W-1]};
  assign rb_sh = {rb_q, qb_q[MAG_W-1]};
  assign ge_a  = ra_sh >= g_ext;
  assign ge_b  = rb_sh >= g_ext;
  assign num_mag = {1'b0, qa_q};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (avail_i) begin
          state_d = (job_i.status == ST_OK) ? FSM_GCD : FSM_DONE;
        end
      end
      FSM_GCD: begin
        if (gcd_done) begin
          state_d = FSM_DIV;
        end
      end
      FSM_DIV: begin
        if (cnt_q == '0) begin
          state_d = FSM_DONE;
        end
      end
      FSM_DONE: begin
        if (res_free) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    x_d         = x_q;
    y_d         = y_q;
    k_d         = k_q;
    g_d         = g_q;
    qa_d        = qa_q;
    qb_d        = qb_q;
    ra_d        = ra_q;
    rb_d        = rb_q;
    cnt_d       = cnt_q;
    neg_d       = neg_q;
    status_d    = status_q;
    res_valid_d = res_valid_q && !pop;
    res_d       = res_q;
    unique case (state_q)
      FSM_IDLE: begin
        x_d      = job_i.mag_num;
        y_d      = job_i.mag_den;
        qa_d     = job_i.mag_num;
        qb_d     = job_i.mag_den;
        k_d      = '0;
        neg_d    = job_i.neg;
        status_d = job_i.status;
      end
      FSM_GCD: begin
        // one Stein step per cycle; a zero on either side ends the search
        priority if (gcd_done) begin
          g_d   = (x_q | y_q) << k_q;
          ra_d  = '0;
          rb_d  = '0;
          cnt_d = BIT_CNT_W'(MAG_W - 1);
        end else if (!x_q[0] && !y_q[0]) begin
          x_d = x_q >> 1;
          y_d = y_q >> 1;
          k_d = k_q + 1'b1;
        end else if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (x_q >= y_q) begin
          x_d = x_q - y_q;
        end else begin
          y_d = y_q - x_q;
        end
      end
      FSM_DIV: begin
        ra_d  = ge_a ? ra_sh[MAG_W-1:0] - g_q : ra_sh[MAG_W-1:0];
        rb_d  = ge_b ? rb_sh[MAG_W-1:0] - g_q : rb_sh[MAG_W-1:0];
        qa_d  = {qa_q[MAG_W-2:0], ge_a};
        qb_d  = {qb_q[MAG_W-2:0], ge_b};
        cnt_d = cnt_q - 1'b1;
      end
      FSM_DONE: begin
        if (res_free) begin
          res_valid_d = 1'b1;
          res_d.status = status_q;
          if (status_q == ST_OK) begin
            res_d.reduced_numerator   = neg_q ? (~num_mag + 1'b1) : num_mag;
            res_d.reduced_denominator = qb_q;
            res_d.whole_number        = (qb_q == MAG_W'(1));
          end else begin
            res_d.reduced_numerator   = '0;
            res_d.reduced_denominator = '0;
            res_d.whole_number        = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q      <= x_d;
    y_q      <= y_d;
    k_q      <= k_d;
    g_q      <= g_d;
    qa_q     <= qa_d;
    qb_q     <= qb_d;
    ra_q     <= ra_d;
    rb_q     <= rb_d;
    cnt_q    <= cnt_d;
    neg_q    <= neg_d;
    status_q <= status_d;
    res_q    <= res_d;
  end

  assign empty = !res_valid_q;
  assign out_o = res_q;

`ifndef SYNTHESIS
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FSM_DIV |-> g_q != '0)
    else $error("division by zero divisor");
  a_ok_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.status == ST_OK |-> res_q.reduced_denominator != '0)
    else $error("zero denominator in an ok result");
  a_whole_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.whole_number |-> res_q.status == ST_OK)
    else $error("whole number flag on an error result");
`endif

endmodule

### hdl/fraction_reducer_unit.sv
// Fraction reducer: reduces a signed fraction to lowest terms.
// Usage:
//   Input queue side: drive in_i and raise push; the item is taken at an edge
//   where push is high and full is low. Two classified items can wait between
//   the front end and the arithmetic back end.
//   Result queue side: while empty is low the oldest result sits on out_o; it
//   is taken at an edge where pop is high and empty is low.
// Flow: an item with a zero denominator or a -2^31 operand skips the GCD and
//   the dividers and goes to the result register. A normal item passes through
//   the binary GCD (one shift or one subtract per cycle), then a pair of
//   restoring dividers with a shared counter that produce both quotients
//   together, then the result register.
// The back end works on one item at a time and takes the next only when done
//   with the last; the front end keeps taking items until the queue is full.
// A stalled result queue holds its item; the back end finishes the next item
//   and waits, then the input queue fills and full rises.
// Reset (rst_ni low, asynchronous) empties both queues and returns the back
//   end to idle; no clearing pass is needed.
// Depends on fr_pkg, fr_front, fr_queue and fr_back.
module fraction_reducer_unit import fr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push,
  output logic    full,
  input  fr_in_t  in_i,
  output logic    empty,
  input  logic    pop,
  output fr_out_t out_o
);

  fr_job_wr_t wr;
  fr_job_t    head;
  logic       queue_full;
  logic       queue_avail;
  logic       rd_en;

  fr_front u_front (
    .push         (push),
    .in_i         (in_i),
    .queue_full_i (queue_full),
    .full         (full),
    .wr_o         (wr)
  );

  fr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .rd_en_i (rd_en),
    .full_o  (queue_full),
    .avail_o (queue_avail),
    .head_o  (head)
  );

  fr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .avail_i (queue_avail),
    .job_i   (head),
    .rd_en_o (rd_en),
    .pop     (pop),
    .empty   (empty),
    .out_o   (out_o)
  );

endmodule

### test/fraction_reducer_unit_tb.sv
// Self-checking testbench for fraction_reducer_unit: a directed table, then
// random fractions, checked against a GCD-based predictor. Uses fr_pkg.
// Traffic goes through phases of sender gaps, receiver stalls and a long hold-off.
module fraction_reducer_unit_tb import fr_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM      = 1700;
  localparam int HOLD_CYCLES   = 1500;
  localparam int DRAIN_CYCLES  = 250;
  localparam int MAX_REPORTS   = 20;
  localparam logic [WORD_BITS-1:0] MOST_NEG = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [WORD_BITS-1:0] MAX_POS  = ~MOST_NEG;

  typedef enum int {
    PH_FREE,
    PH_SEND_IDLE,
    PH_RECV_STALL,
    PH_BOTH,
    PH_HOLD
  } traffic_e;

  typedef struct {
    fr_in_t  item;
    bit      typed;
    fr_out_t want;
  } dir_row_t;

  logic    clk_i;
  logic    rst_ni;
  logic    push;
  logic    full;
  fr_in_t  in_i;
  logic    empty;
  logic    pop;
  fr_out_t out_o;

  traffic_e traffic = PH_FREE;
  fr_out_t  expected_q[$];
  dir_row_t dir_rows[$];
  fr_out_t  oldest;
  int       errors = 0;
  int       items_sent = 0;
  int       results_seen = 0;
  int       zero_den_seen = 0;
  int       overflow_seen = 0;
  int       whole_seen = 0;
  int       full_stall_cycles = 0;

  fraction_reducer_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push   (push),
    .full   (full),
    .in_i   (in_i),
    .empty  (empty),
    .pop    (pop),
    .out_o  (out_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Lowest terms by Euclid; the sign always ends up on the numerator
  function automatic fr_out_t reduce_fraction(input fr_in_t x);
    fr_out_t r;
    logic [WORD_BITS-1:0] n, d, a, b, g, t, q_num, q_den;
    n = x.numerator;
    d = x.denominator;
    r = '0;
    if (d == '0) begin
      r.status = ST_ZERO_DEN;
    end else if (n == MOST_NEG || d == MOST_NEG) begin
      r.status = ST_OVERFLOW;
    end else begin
      a = n[WORD_BITS-1] ? -n : n;
      b = d[WORD_BITS-1] ? -d : d;
      g = a;
      t = b;
      while (t != '0) begin
        q_num = g % t;
        g = t;
        t = q_num;
      end
      q_num = a / g;
      q_den = b / g;
      r.reduced_numerator   = (n[WORD_BITS-1] ^ d[WORD_BITS-1]) ? -q_num : q_num;
      r.reduced_denominator = q_den[WORD_BITS-2:0];
      r.whole_number        = (q_den == 1);
      r.status              = ST_OK;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("[%0t] mismatch on %s: got %0d, expected %0d (result %0d)",
               $realtime, what, got, want, results_seen);
  endtask

  task automatic add_row(input logic [WORD_BITS-1:0] num, input logic [WORD_BITS-1:0] den,
                         input bit typed, input fr_out_t want);
    dir_row_t row;
    row.item.numerator   = num;
    row.item.denominator = den;
    row.typed            = typed;
    row.want             = want;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // Offer one item, with random gaps as the phase asks, until it is taken
  task automatic send_item(input fr_in_t item, input bit typed, input fr_out_t want);
    bit idle;
    do begin
      @(negedge clk_i);
      idle = ((traffic == PH_SEND_IDLE) && ($urandom_range(0, 99) < 67)) ||
             ((traffic == PH_BOTH) && ($urandom_range(0, 99) < 12));
      if (idle) push <= 1'b0;
    end while (idle);
    push <= 1'b1;
    in_i <= item;
    do begin
      @(posedge clk_i);
      if (full) full_stall_cycles++;
    end while (full);
    expected_q.insert(expected_q.size(), typed ? want : reduce_fraction(item));
    items_sent++;
  endtask

  // Receiver: random stalls per phase, plus one long hold-off when the hold phase opens
  initial begin : receiver
    traffic_e seen;
    int       hold_left;
    seen      = PH_FREE;
    hold_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (traffic != seen) begin
        seen = traffic;
        if (traffic == PH_HOLD) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= !(((traffic == PH_RECV_STALL) && ($urandom_range(0, 99) < 67)) ||
                 ((traffic == PH_BOTH) && ($urandom_range(0, 99) < 12)));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing expected",
                        longint'($signed(out_o.reduced_numerator)), 0);
      end else begin
        oldest = expected_q.pop_front();
        if (out_o.reduced_numerator !== oldest.reduced_numerator)
          report_mismatch("reduced_numerator", longint'($signed(out_o.reduced_numerator)),
                          longint'($signed(oldest.reduced_numerator)));
        if (out_o.reduced_denominator !== oldest.reduced_denominator)
          report_mismatch("reduced_denominator", longint'(out_o.reduced_denominator),
                          longint'(oldest.reduced_denominator));
        if (out_o.whole_number !== oldest.whole_number)
          report_mismatch("whole_number", longint'(out_o.whole_number),
                          longint'(oldest.whole_number));
        if (out_o.status !== oldest.status)
          report_mismatch("status", longint'(out_o.status), longint'(oldest.status));
      end
      results_seen++;
      if (out_o.status == ST_ZERO_DEN) zero_den_seen++;
      if (out_o.status == ST_OVERFLOW) overflow_seen++;
      if (out_o.whole_number) whole_seen++;
    end
  end

  initial begin : stimulus
    fr_in_t  item;
    fr_out_t none;
    int      kind;
    int      k;
    int      n_directed;
    none   = '0;
    rst_ni = 1'b0;
    push   = 1'b0;
    in_i   = '0;

    // Errors: zero denominator wins over the most negative operand
    add_row(5, 0, 1, '{'0, '0, 1'b0, ST_ZERO_DEN});
    add_row(0, 0, 1, '{'0, '0, 1'b0, ST_ZERO_DEN});
    add_row(MOST_NEG, 0, 1, '{'0, '0, 1'b0, ST_ZERO_DEN});
    add_row(MOST_NEG, 1, 1, '{'0, '0, 1'b0, ST_OVERFLOW});
    add_row(1, MOST_NEG, 1, '{'0, '0, 1'b0, ST_OVERFLOW});
    add_row(MOST_NEG, MOST_NEG, 1, '{'0, '0, 1'b0, ST_OVERFLOW});
    // Zero numerator reduces to 0/1
    add_row(0, 7, 1, '{'0, 31'd1, 1'b1, ST_OK});
    add_row(0, -7, 1, '{'0, 31'd1, 1'b1, ST_OK});
    add_row(0, MAX_POS, 1, '{'0, 31'd1, 1'b1, ST_OK});
    // Extremes
    add_row(1, 1, 1, '{32'sd1, 31'd1, 1'b1, ST_OK});
    add_row(MAX_POS, MAX_POS, 1, '{32'sd1, 31'd1, 1'b1, ST_OK});
    add_row(-MAX_POS, -MAX_POS, 1, '{32'sd1, 31'd1, 1'b1, ST_OK});
    add_row(MAX_POS, 1, 1, '{MAX_POS, 31'd1, 1'b1, ST_OK});
    add_row(-MAX_POS, 1, 1, '{-MAX_POS, 31'd1, 1'b1, ST_OK});
    add_row(1, MAX_POS, 1, '{32'sd1, MAX_POS[WORD_BITS-2:0], 1'b0, ST_OK});
    add_row(1, -MAX_POS, 1, '{-32'sd1, MAX_POS[WORD_BITS-2:0], 1'b0, ST_OK});
    add_row(-1, -1, 1, '{32'sd1, 31'd1, 1'b1, ST_OK});
    // Ordinary reductions and sign placement
    add_row(6, -4, 0, none);
    add_row(-6, -4, 0, none);
    add_row(-12, 8, 0, none);
    add_row(32'sd1 << 30, 32'sd1 << 29, 0, none);
    add_row(MAX_POS, MAX_POS - 1, 0, none);
    add_row(-1000000, 999999, 0, none);
    add_row(46368, -28657, 0, none);
    n_directed = dir_rows.size();

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    for (int i = 0; i < N_RANDOM; i++) begin
      traffic = traffic_e'(i * 5 / N_RANDOM);
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        item.numerator   = $urandom();
        item.denominator = $urandom();
      end else if (kind < 70) begin
        // Shared factor, so the reduction actually does something
        k = $urandom_range(1, 1 << 15);
        item.numerator   = k * $urandom_range(0, 1 << 15);
        item.denominator = k * $urandom_range(1, 1 << 15);
        if ($urandom_range(0, 1)) item.numerator = -item.numerator;
        if ($urandom_range(0, 1)) item.denominator = -item.denominator;
      end else if (kind < 80) begin
        item.numerator   = int'($urandom_range(0, 40)) - 20;
        item.denominator = int'($urandom_range(0, 40)) - 20;
      end else if (kind < 85) begin
        item.numerator   = ($urandom_range(0, 7) | 1) << $urandom_range(0, 28);
        item.denominator = ($urandom_range(0, 7) | 1) << $urandom_range(0, 28);
        if ($urandom_range(0, 1)) item.numerator = -item.numerator;
        if ($urandom_range(0, 1)) item.denominator = -item.denominator;
      end else if (kind < 89) begin
        item.numerator   = $urandom();
        item.denominator = '0;
      end else if (kind < 93) begin
        item.numerator   = $urandom_range(0, 1) ? MOST_NEG : $urandom();
        item.denominator = (item.numerator == MOST_NEG) ? $urandom() : MOST_NEG;
      end else if (kind < 97) begin
        item.numerator   = '0;
        item.denominator = $urandom();
      end else begin
        item.numerator   = $urandom();
        item.denominator = $urandom_range(0, 1) ? item.numerator : -item.numerator;
        if ($urandom_range(0, 1)) item.denominator = $urandom_range(0, 1) ? 1 : -1;
      end
      send_item(item, 0, none);
    end

    @(negedge clk_i);
    push <= 1'b0;
    traffic = PH_FREE;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_q.size() != 0)
      report_mismatch("results never delivered", 0, expected_q.size());

    $display("Covered %0d items (%0d from the table), %0d results: %0d zero denominator,",
             items_sent, n_directed, results_seen, zero_den_seen);
    $display("%0d overflow, %0d whole numbers; input held off by full for %0d cycles.",
             overflow_seen, whole_seen, full_stall_cycles);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("Timed out with %0d results still expected", expected_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
